// File: rtl/asef_pkg.sv
// Shared constants, command and status types for the ANSI SGR escape filter.
package asef_pkg;

    localparam int ESC_BUF_DEPTH_DEF = 32;

    localparam int CHAR_W  = 16;
    localparam int BUF_W   = 8;
    localparam int COLOR_W = 3;
    localparam int KIND_W  = 2;
    localparam int VAL_W   = 8;
    localparam int OUT_W   = CHAR_W + 2 * COLOR_W + 2;

    localparam logic [CHAR_W-1:0] CH_ESC  = 16'd27;
    localparam logic [CHAR_W-1:0] CH_BS   = 16'd8;
    localparam logic [CHAR_W-1:0] CH_BEL  = 16'd7;
    localparam logic [CHAR_W-1:0] CH_M    = 16'h006D;
    localparam logic [CHAR_W-1:0] CH_SEMI = 16'h003B;
    localparam logic [CHAR_W-1:0] CH_LBR  = 16'h005B;
    localparam logic [CHAR_W-1:0] CH_D0   = 16'h0030;
    localparam logic [CHAR_W-1:0] CH_D9   = 16'h0039;

    localparam logic [KIND_W-1:0] KIND_CHAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BS   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BEL  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

    localparam logic [0:0] REG_DEFAULT_FORE = 1'b0;
    localparam logic [0:0] REG_DEFAULT_BACK = 1'b1;

    localparam logic [COLOR_W-1:0] FORE_RESET = 3'd0;
    localparam logic [COLOR_W-1:0] BACK_RESET = 3'd7;

    localparam logic [VAL_W-1:0] SGR_RESET     = 8'd0;
    localparam logic [VAL_W-1:0] SGR_BOLD      = 8'd1;
    localparam logic [VAL_W-1:0] SGR_UNDERLINE = 8'd4;
    localparam logic [VAL_W-1:0] SGR_FG_LO     = 8'd30;
    localparam logic [VAL_W-1:0] SGR_FG_HI     = 8'd37;
    localparam logic [VAL_W-1:0] SGR_BG_LO     = 8'd40;
    localparam logic [VAL_W-1:0] SGR_BG_HI     = 8'd47;
    localparam logic [VAL_W-1:0] VAL_MAX       = 8'd255;

    typedef struct packed {
        logic pend_ld;
        logic buf_wr;
        logic esc_open;
        logic esc_close;
        logic idx_clr;
        logic idx_inc;
        logic val_clr;
        logic par_step;
        logic out_rep;
        logic out_pend;
    } cmd_t;

    typedef struct packed {
        logic s_is_m;
        logic s_is_buf;
        logic s_is_esc;
        logic in_esc;
        logic cnt_zero;
        logic cnt_full;
        logic idx_last;
        logic idx_end;
        logic lbr_ok;
        logic pend_is_esc;
        logic out_free;
    } sts_t;

endpackage

// File: rtl/asef_ctrl.sv
// Controller state machine: accepts items, sequences buffer replay and SGR field parsing.
module asef_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  asef_pkg::sts_t sts,
    output asef_pkg::cmd_t cmd
);
    import asef_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_EMIT     = 8'b0000_0010,
        ST_REP_RD   = 8'b0000_0100,
        ST_REP_OUT  = 8'b0000_1000,
        ST_PAR_RD0  = 8'b0001_0000,
        ST_PAR_CHK  = 8'b0010_0000,
        ST_PAR_RD   = 8'b0100_0000,
        ST_PAR_STEP = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.pend_ld = 1'b1;
                    if (sts.in_esc && sts.s_is_m)
                    begin
                        cmd.esc_close = 1'b1;
                        if (!sts.cnt_zero)
                        begin
                            cmd.idx_clr = 1'b1;
                            state_next  = ST_PAR_RD0;
                        end
                    end
                    else if (sts.in_esc && sts.s_is_buf)
                    begin
                        cmd.buf_wr = !sts.cnt_full;
                    end
                    else
                    begin
                        cmd.esc_close = sts.in_esc;
                        if (sts.in_esc && !sts.cnt_zero)
                        begin
                            cmd.idx_clr = 1'b1;
                            state_next  = ST_REP_RD;
                        end
                        else if (sts.s_is_esc)
                        begin
                            cmd.esc_open = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_EMIT;
                        end
                    end
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_pend = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_REP_RD:
            begin
                state_next = ST_REP_OUT;
            end
            ST_REP_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_rep = 1'b1;
                    cmd.idx_inc = 1'b1;
                    if (!sts.idx_last)
                    begin
                        state_next = ST_REP_RD;
                    end
                    else if (sts.pend_is_esc)
                    begin
                        cmd.esc_open = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_PAR_RD0:
            begin
                state_next = ST_PAR_CHK;
            end
            ST_PAR_CHK:
            begin
                if (sts.lbr_ok)
                begin
                    cmd.idx_inc = 1'b1;
                    cmd.val_clr = 1'b1;
                    state_next  = ST_PAR_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PAR_RD:
            begin
                state_next = ST_PAR_STEP;
            end
            ST_PAR_STEP:
            begin
                cmd.par_step = 1'b1;
                if (sts.idx_end)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_PAR_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/asef_dp.sv
// Datapath: escape buffer, SGR field accumulator, attribute and config registers, output register.
module asef_dp #(
    parameter int ESC_BUF_DEPTH = asef_pkg::ESC_BUF_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  asef_pkg::cmd_t                cmd,
    output asef_pkg::sts_t                sts,
    input  logic [asef_pkg::CHAR_W-1:0]   s_tdata,
    input  logic                          cfg_valid,
    input  logic [0:0]                    cfg_index,
    input  logic [asef_pkg::COLOR_W-1:0]  cfg_data,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [asef_pkg::OUT_W-1:0]    m_tdata,
    output logic [asef_pkg::KIND_W-1:0]   m_tuser,
    output logic                          m_tlast
);
    import asef_pkg::*;

    localparam int AW = (ESC_BUF_DEPTH > 1) ? $clog2(ESC_BUF_DEPTH) : 1;
    localparam int CW = $clog2(ESC_BUF_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(ESC_BUF_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    logic [BUF_W-1:0]   esc_mem [ESC_BUF_DEPTH];
    logic [BUF_W-1:0]   rd_data_reg;
    logic               in_esc_reg;
    logic [CW-1:0]      cnt_reg;
    logic [CW-1:0]      idx_reg;
    logic [VAL_W-1:0]   val_reg;
    logic [VAL_W-1:0]   val_next;
    logic               stop_reg;
    logic [CHAR_W-1:0]  pend_reg;
    logic [COLOR_W-1:0] dfore_reg;
    logic [COLOR_W-1:0] dback_reg;
    logic [COLOR_W-1:0] fore_reg;
    logic [COLOR_W-1:0] fore_next;
    logic [COLOR_W-1:0] back_reg;
    logic [COLOR_W-1:0] back_next;
    logic               bold_reg;
    logic               bold_next;
    logic               ul_reg;
    logic               ul_next;
    logic               out_valid_reg;
    logic [OUT_W-1:0]   out_data_reg;
    logic [KIND_W-1:0]  out_kind_reg;
    logic               out_last_reg;

    logic [CHAR_W-1:0]  step_char;
    logic               step_semi;
    logic               step_digit;
    logic [11:0]        acc;
    logic [VAL_W-1:0]   fg_code;
    logic [VAL_W-1:0]   bg_code;
    logic [KIND_W-1:0]  pend_kind;
    logic [CHAR_W-1:0]  pend_char;
    logic               out_load;

    always_comb
    begin
        sts.s_is_m      = (s_tdata == CH_M);
        sts.s_is_buf    = (s_tdata >= CH_D0 && s_tdata <= CH_D9) || s_tdata == CH_SEMI
                          || s_tdata == CH_LBR;
        sts.s_is_esc    = (s_tdata == CH_ESC);
        sts.in_esc      = in_esc_reg;
        sts.cnt_zero    = (cnt_reg == '0);
        sts.cnt_full    = (cnt_reg == DEPTH_C);
        sts.idx_last    = (idx_reg == cnt_reg - ONE_C);
        sts.idx_end     = (idx_reg == cnt_reg);
        sts.lbr_ok      = ({{(CHAR_W-BUF_W){1'b0}}, rd_data_reg} == CH_LBR);
        sts.pend_is_esc = (pend_reg == CH_ESC);
        sts.out_free    = !out_valid_reg || m_tready;
    end

    // escape buffer, single write port and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.buf_wr)
        begin
            esc_mem[cnt_reg[AW-1:0]] <= s_tdata[BUF_W-1:0];
        end
        rd_data_reg <= esc_mem[idx_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pend_ld)
        begin
            pend_reg <= s_tdata;
        end
    end

    // field walk: last step is a virtual ';'
    always_comb
    begin
        step_char  = sts.idx_end ? CH_SEMI : {{(CHAR_W-BUF_W){1'b0}}, rd_data_reg};
        step_semi  = (step_char == CH_SEMI);
        step_digit = (step_char >= CH_D0) && (step_char <= CH_D9);
        acc        = {4'd0, val_reg} * 12'd10 + {8'd0, step_char[3:0]};
        val_next   = val_reg;
        if (cmd.val_clr)
        begin
            val_next = '0;
        end
        else if (cmd.par_step)
        begin
            if (step_semi)
            begin
                val_next = '0;
            end
            else if (step_digit && !stop_reg)
            begin
                val_next = (acc > {4'd0, VAL_MAX}) ? VAL_MAX : acc[VAL_W-1:0];
            end
        end
    end

    always_comb
    begin
        fg_code   = val_reg - SGR_FG_LO;
        bg_code   = val_reg - SGR_BG_LO;
        fore_next = fore_reg;
        back_next = back_reg;
        bold_next = bold_reg;
        ul_next   = ul_reg;
        if (cmd.par_step && step_semi)
        begin
            if (val_reg == SGR_RESET)
            begin
                fore_next = dfore_reg;
                back_next = dback_reg;
                bold_next = 1'b0;
                ul_next   = 1'b0;
            end
            else if (val_reg == SGR_BOLD)
            begin
                bold_next = 1'b1;
            end
            else if (val_reg == SGR_UNDERLINE)
            begin
                ul_next = 1'b1;
            end
            else if (val_reg >= SGR_FG_LO && val_reg <= SGR_FG_HI)
            begin
                fore_next = fg_code[COLOR_W-1:0];
            end
            else if (val_reg >= SGR_BG_LO && val_reg <= SGR_BG_HI)
            begin
                back_next = bg_code[COLOR_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (pend_reg == CH_BS)
        begin
            pend_kind = KIND_BS;
            pend_char = '0;
        end
        else if (pend_reg == CH_BEL)
        begin
            pend_kind = KIND_BEL;
            pend_char = '0;
        end
        else
        begin
            pend_kind = KIND_CHAR;
            pend_char = pend_reg;
        end
    end

    assign out_load = cmd.out_rep || cmd.out_pend;

    always_ff @(posedge clk)
    begin
        if (cmd.out_rep)
        begin
            out_data_reg <= {ul_reg, bold_reg, back_reg, fore_reg,
                             {(CHAR_W-BUF_W){1'b0}}, rd_data_reg};
            out_kind_reg <= KIND_CHAR;
            out_last_reg <= sts.idx_last && sts.pend_is_esc;
        end
        else if (cmd.out_pend)
        begin
            out_data_reg <= {ul_reg, bold_reg, back_reg, fore_reg, pend_char};
            out_kind_reg <= pend_kind;
            out_last_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_esc_reg    <= 1'b0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            val_reg       <= '0;
            stop_reg      <= 1'b0;
            dfore_reg     <= FORE_RESET;
            dback_reg     <= BACK_RESET;
            fore_reg      <= FORE_RESET;
            back_reg      <= BACK_RESET;
            bold_reg      <= 1'b0;
            ul_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.esc_open)
            begin
                in_esc_reg <= 1'b1;
                cnt_reg    <= '0;
            end
            else
            begin
                if (cmd.esc_close)
                begin
                    in_esc_reg <= 1'b0;
                end
                if (cmd.buf_wr)
                begin
                    cnt_reg <= cnt_reg + ONE_C;
                end
            end

            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + ONE_C;
            end

            val_reg <= val_next;
            if (cmd.val_clr || (cmd.par_step && step_semi))
            begin
                stop_reg <= 1'b0;
            end
            else if (cmd.par_step && !(step_digit && !stop_reg))
            begin
                stop_reg <= 1'b1;
            end

            if (cfg_valid && cfg_index == REG_DEFAULT_FORE)
            begin
                dfore_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == REG_DEFAULT_BACK)
            begin
                dback_reg <= cfg_data;
            end

            fore_reg <= fore_next;
            back_reg <= back_next;
            bold_reg <= bold_next;
            ul_reg   <= ul_next;

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: rtl/ansi_sgr_escape_filter.sv
// Top level of the ANSI SGR escape filter: controller, datapath and port wiring.
// A plain char, backspace or bell is held in the pending register, then output from EMIT.
// Input is taken only in IDLE, not in EMIT; ESC, buffered chars and empty closes stay in IDLE.
// An abort replays the buffered chars via the buffer's registered read, a read and an output state
// per entry, output stalls adding on; a close checks for '[' and then walks the fields.
// Reset (rst_n, async, active low) clears control, defaults and attributes; buffer is undefined.
module ansi_sgr_escape_filter #(
    parameter int ESC_BUF_DEPTH = asef_pkg::ESC_BUF_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [asef_pkg::CHAR_W-1:0]   s_tdata,   // [15:0] char_code
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [0:0]                    cfg_index,
    input  logic [asef_pkg::COLOR_W-1:0]  cfg_data,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [15:0] out_char, [18:16] fore_color, [21:19] back_color, [22] bold, [23] underline
    output logic [asef_pkg::OUT_W-1:0]    m_tdata,
    output logic [asef_pkg::KIND_W-1:0]   m_tuser,   // [1:0] kind
    output logic                          m_tlast
);
    import asef_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    asef_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    asef_dp #(
        .ESC_BUF_DEPTH (ESC_BUF_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_rep || cmd.out_pend) |-> sts.out_free)
        else $error("result loaded while output register still held an item");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.buf_wr |-> !sts.cnt_full)
        else $error("escape buffer written past its depth");

    a_ctrl_kind_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == KIND_BS || m_tuser == KIND_BEL)) |-> m_tlast)
        else $error("backspace or bell result not marked last");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser != KIND_NONE))
        else $error("undefined result kind");

endmodule

// File: dv/asef_checker.sv
// Checker for the ANSI SGR escape filter: predicts results and compares them per field.
module asef_checker
    import asef_pkg::*;
#(
    parameter int DEPTH = ESC_BUF_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [CHAR_W-1:0]    s_tdata,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [0:0]           cfg_index,
    input  logic [COLOR_W-1:0]   cfg_data,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [OUT_W-1:0]     m_tdata,
    input  logic [KIND_W-1:0]    m_tuser,
    input  logic                 m_tlast,
    output int                   err_cnt,
    output int                   pending,
    output int                   checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [CHAR_W-1:0]  ch;
        logic [COLOR_W-1:0] fore;
        logic [COLOR_W-1:0] back;
        logic               bold;
        logic               uline;
        logic               last;
    } glyph_t;

    glyph_t             glyph_q[$];
    glyph_t             burst[$];
    logic               in_esc;
    int                 esc_cnt;
    logic [BUF_W-1:0]   esc_buf [DEPTH];
    logic [COLOR_W-1:0] def_fore;
    logic [COLOR_W-1:0] def_back;
    logic [COLOR_W-1:0] cur_fore;
    logic [COLOR_W-1:0] cur_back;
    logic               cur_bold;
    logic               cur_uline;
    int                 mismatches;
    int                 seen;

    function automatic void emit(logic [KIND_W-1:0] k, logic [CHAR_W-1:0] c);
        glyph_t g;
        g.kind  = k;
        g.ch    = c;
        g.fore  = cur_fore;
        g.back  = cur_back;
        g.bold  = cur_bold;
        g.uline = cur_uline;
        g.last  = 1'b0;
        burst.push_back(g);
    endfunction

    function automatic void sgr_apply(logic [VAL_W-1:0] code);
        if (code == SGR_RESET)
        begin
            cur_fore  = def_fore;
            cur_back  = def_back;
            cur_bold  = 1'b0;
            cur_uline = 1'b0;
        end
        else if (code == SGR_BOLD)
            cur_bold = 1'b1;
        else if (code == SGR_UNDERLINE)
            cur_uline = 1'b1;
        else if (code >= SGR_FG_LO && code <= SGR_FG_HI)
            cur_fore = COLOR_W'(code - SGR_FG_LO);
        else if (code >= SGR_BG_LO && code <= SGR_BG_HI)
            cur_back = COLOR_W'(code - SGR_BG_LO);
    endfunction

    // Walk "[f0;f1;..." left to right; the end of the buffer closes the last field.
    function automatic void sgr_close();
        int                val;
        int                i;
        logic              stopped;
        logic [CHAR_W-1:0] c;
        val     = 0;
        stopped = 1'b0;
        if (esc_cnt == 0 || CHAR_W'(esc_buf[0]) != CH_LBR)
            return;
        for (i = 1; i <= esc_cnt; i++)
        begin
            c = (i < esc_cnt) ? CHAR_W'(esc_buf[i]) : CH_SEMI;
            if (c == CH_SEMI)
            begin
                sgr_apply(VAL_W'(val));
                val     = 0;
                stopped = 1'b0;
            end
            else if (c >= CH_D0 && c <= CH_D9 && !stopped)
            begin
                val = val * 10 + int'(c - CH_D0);
                if (val > int'(VAL_MAX))
                    val = int'(VAL_MAX);
            end
            else
                stopped = 1'b1;
        end
    endfunction

    function automatic void predict_char(logic [CHAR_W-1:0] c);
        logic   is_buf;
        int     i;
        glyph_t g;
        is_buf = (c >= CH_D0 && c <= CH_D9) || c == CH_SEMI || c == CH_LBR;
        burst.delete();
        if (in_esc && c == CH_M)
        begin
            sgr_close();
            in_esc = 1'b0;
            return;
        end
        if (in_esc && is_buf)
        begin
            if (esc_cnt < DEPTH)
            begin
                esc_buf[esc_cnt] = c[BUF_W-1:0];
                esc_cnt++;
            end
            return;
        end
        if (in_esc)
        begin
            // aborted: buffered chars go out as text, then c as usual
            in_esc = 1'b0;
            for (i = 0; i < esc_cnt; i++)
                emit(KIND_CHAR, CHAR_W'(esc_buf[i]));
        end
        if (c == CH_BS)
            emit(KIND_BS, '0);
        else if (c == CH_BEL)
            emit(KIND_BEL, '0);
        else if (c == CH_ESC)
        begin
            in_esc  = 1'b1;
            esc_cnt = 0;
        end
        else
            emit(KIND_CHAR, c);
        if (burst.size() > 0)
        begin
            g      = burst.pop_back();
            g.last = 1'b1;
            burst.push_back(g);
        end
        foreach (burst[k])
            glyph_q.push_back(burst[k]);
    endfunction

    always @(posedge clk)
    begin
        glyph_t got;
        glyph_t want;
        if (!rst_n)
        begin
            def_fore   = FORE_RESET;
            def_back   = BACK_RESET;
            cur_fore   = FORE_RESET;
            cur_back   = BACK_RESET;
            cur_bold   = 1'b0;
            cur_uline  = 1'b0;
            in_esc     = 1'b0;
            esc_cnt    = 0;
            mismatches = 0;
            seen       = 0;
            glyph_q.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.kind  = m_tuser;
                got.ch    = m_tdata[CHAR_W-1:0];
                got.fore  = m_tdata[CHAR_W +: COLOR_W];
                got.back  = m_tdata[CHAR_W+COLOR_W +: COLOR_W];
                got.bold  = m_tdata[CHAR_W+2*COLOR_W];
                got.uline = m_tdata[CHAR_W+2*COLOR_W+1];
                got.last  = m_tlast;
                seen++;
                if (glyph_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] result with none expected: kind=%0d char=%h last=%0b",
                                 $time, got.kind, got.ch, got.last);
                end
                else
                begin
                    want = glyph_q.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("[%0t] mismatch: exp kind=%0d char=%h fg=%0d bg=%0d bold=%0b ul=%0b last=%0b",
                                     $time, want.kind, want.ch, want.fore, want.back,
                                     want.bold, want.uline, want.last);
                            $display("              got kind=%0d char=%h fg=%0d bg=%0d bold=%0b ul=%0b last=%0b",
                                     got.kind, got.ch, got.fore, got.back,
                                     got.bold, got.uline, got.last);
                        end
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_DEFAULT_FORE)
                    def_fore = cfg_data;
                else if (cfg_index == REG_DEFAULT_BACK)
                    def_back = cfg_data;
            end
            if (s_tvalid && s_tready)
                predict_char(s_tdata);
        end
        err_cnt <= mismatches;
        pending <= glyph_q.size();
        checked <= seen;
    end

endmodule

// File: dv/tb.sv
// Top of the escape filter testbench: clock, reset, stimulus, flow control and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import asef_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 100;
    localparam int HOLD_CYCLES = 400;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [CHAR_W-1:0]   s_tdata = '0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [0:0]          cfg_index = '0;
    logic [COLOR_W-1:0]  cfg_data = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_W-1:0]    m_tdata;
    logic [KIND_W-1:0]   m_tuser;
    logic                m_tlast;

    int err_cnt;
    int pending;
    int checked;
    int items_sent = 0;
    int cfg_writes = 0;
    bit calm = 1'b0;
    bit stall_req = 1'b0;

    // plain extremes, ignored non-'[' sequence, abort by ESC, then a sequence with an
    // empty field, a saturating value and a stray '[' inside a field
    logic [CHAR_W-1:0] warmup[] = '{
        16'h0000, 16'hFFFF, CH_BS, CH_BEL,
        CH_ESC, CH_D0 + 16'd4, CH_M,
        CH_ESC, CH_LBR, CH_D0 + 16'd1, CH_SEMI, CH_D0 + 16'd4, CH_D0 + 16'd2, CH_ESC,
        CH_LBR, CH_SEMI, CH_D0 + 16'd2, CH_D0 + 16'd8, CH_D0 + 16'd7, CH_SEMI,
        CH_D0 + 16'd4, CH_LBR, CH_D0 + 16'd1, CH_M,
        16'h005A
    };
    logic [COLOR_W-1:0] fore_set[4] = '{3'd7, 3'd3, 3'd0, 3'd7};
    logic [COLOR_W-1:0] back_set[4] = '{3'd0, 3'd5, 3'd0, 3'd7};

    ansi_sgr_escape_filter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    asef_checker u_chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .err_cnt   (err_cnt),
        .pending   (pending),
        .checked   (checked)
    );

    always #1 clk = ~clk;

    task automatic send(logic [CHAR_W-1:0] c);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 17)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = c;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic write_reg(logic [0:0] idx, logic [COLOR_W-1:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
        cfg_writes++;
    endtask

    // no results outstanding, then room for a close or abort walk that emits nothing
    task automatic idle_wait();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [CHAR_W-1:0] text_char();
        int pick;
        pick = $urandom_range(9);
        case (pick)
            0:       return CH_BS;
            1:       return CH_BEL;
            2, 3, 4: return CHAR_W'($urandom_range(65535));
            default: return CHAR_W'($urandom_range(126, 32));
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] buf_char();
        int pick;
        pick = $urandom_range(11);
        if (pick < 10)
            return CH_D0 + CHAR_W'(pick);
        else if (pick == 10)
            return CH_SEMI;
        else
            return CH_LBR;
    endfunction

    function automatic int common_code();
        case ($urandom_range(4))
            0:       return int'(SGR_RESET);
            1:       return int'(SGR_BOLD);
            2:       return int'(SGR_UNDERLINE);
            3:       return int'(SGR_FG_LO) + int'($urandom_range(7));
            default: return int'(SGR_BG_LO) + int'($urandom_range(7));
        endcase
    endfunction

    task automatic send_number(int v);
        string s;
        int    i;
        s = $sformatf("%0d", v);
        for (i = 0; i < s.len(); i++)
            send(CHAR_W'(s[i]));
    endtask

    task automatic send_sgr();
        int nf;
        int f;
        int pick;
        send(CH_ESC);
        send(CH_LBR);
        nf = $urandom_range(4, 1);
        for (f = 0; f < nf; f++)
        begin
            if (f > 0)
                send(CH_SEMI);
            pick = $urandom_range(9);
            if (pick >= 1 && pick <= 5)
                send_number(common_code());
            else if (pick == 6 || pick == 7)
                send_number($urandom_range(99));
            else if (pick == 8)
                send_number($urandom_range(999));
            else if (pick == 9)
            begin
                send_number($urandom_range(47));
                send(CH_LBR);
                send_number($urandom_range(9));
            end
        end
        send(CH_M);
    endtask

    task automatic send_text();
        repeat ($urandom_range(4, 1)) send(text_char());
    endtask

    task automatic send_broken();
        int i;
        int n;
        n = $urandom_range(6);
        case ($urandom_range(3))
            0, 1:
            begin
                send(CH_ESC);
                for (i = 0; i < n; i++)
                    send(buf_char());
                send(($urandom_range(3) == 0) ? CH_ESC : text_char());
            end
            2:
            begin
                send(CH_ESC);
                send(CH_D0 + CHAR_W'($urandom_range(9)));
                for (i = 0; i < n; i++)
                    send(buf_char());
                send(CH_M);
            end
            default:
            begin
                send(CH_M);
                send(CH_SEMI);
                send(CH_LBR);
            end
        endcase
    endtask

    task automatic send_overflow();
        int i;
        int n;
        n = $urandom_range(40, 31);
        send(CH_ESC);
        send(CH_LBR);
        for (i = 0; i < n; i++)
            send(buf_char());
        send(($urandom_range(1) == 0) ? CH_M : text_char());
    endtask

    task automatic send_unit();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            send_sgr();
        else if (r < 80)
            send_text();
        else if (r < 97)
            send_broken();
        else
            send_overflow();
    endtask

    initial
    begin
        int hold;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (stall_req)
            begin
                stall_req = 1'b0;
                hold = HOLD_CYCLES;
            end
            if (hold > 0)
            begin
                m_tready = 1'b0;
                hold--;
            end
            else
                m_tready = calm || ($urandom_range(99) >= 17);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        int p;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (warmup[i])
            send(warmup[i]);

        for (p = 0; p < 4; p++)
        begin
            idle_wait();
            write_reg(REG_DEFAULT_FORE,
                      (p == 3) ? COLOR_W'($urandom_range(7)) : fore_set[p]);
            write_reg(REG_DEFAULT_BACK, back_set[p]);
            calm = (p == 2);
            if (p == 1)
                stall_req = 1'b1;
            while (items_sent < warmup.size() + 99 * (p + 1))
                send_unit();
        end
        idle_wait();

        $display("Sent %0d chars: SGR sequences, aborts, overflows and raw text", items_sent);
        $display("Checked %0d results across %0d writes of four color default settings",
                 checked, cfg_writes);
        if (err_cnt == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
